/* design/ceuler_pkg.sv */
// Shared constants and the saturation helper for the conserved-to-primitive Euler core.
`timescale 1ns / 1ps

package ceuler_pkg;

   localparam int FRAC_BITS_DEFAULT = 16;
   localparam int WORD_W = 32;
   localparam int TAG_W = 8;
   localparam int REG_W = 31;
   localparam int CSR_IDX_W = 2;

   localparam logic [REG_W-1:0] GAMMA_RESET = 31'd26214;
   localparam logic [REG_W-1:0] CV_RESET = 31'd65536;

   localparam logic [CSR_IDX_W-1:0] CSR_GAMMA = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_CV = 2'd1;

   // A quotient magnitude at or above this value is clamped to it.
   localparam logic [32:0] MAG_LIMIT = 33'h1_0000_0000;

   typedef logic [32:0] sat_word_type;

   // Applies a sign to a magnitude and saturates; bit 32 of the result flags a clip.
   function automatic sat_word_type sat_to_s32(input logic neg, input logic [32:0] mag);
      sat_word_type result;
      if (neg) begin
         if (mag > 33'h0_8000_0000) begin
            result = {1'b1, 32'h8000_0000};
         end else begin
            result = {1'b0, 32'd0 - mag[31:0]};
         end
      end else begin
         if (mag > 33'h0_7FFF_FFFF) begin
            result = {1'b1, 32'h7FFF_FFFF};
         end else begin
            result = {1'b0, mag[31:0]};
         end
      end
      return result;
   endfunction

endpackage

/* design/ceuler_div_cell.sv */
// One restoring-division cell: produces one quotient bit per clock and hands on to the next cell.
`timescale 1ns / 1ps

module ceuler_div_cell #(
   parameter int RW = 31,
   parameter int NW = 32
) (
   input  logic          clock,
   input  logic [RW-1:0] in_div,
   input  logic [RW-1:0] in_rem,
   input  logic [NW-1:0] in_acc,
   output logic [RW-1:0] out_div,
   output logic [RW-1:0] out_rem,
   output logic [NW-1:0] out_acc
);

   logic [RW:0]   trial;
   logic [RW:0]   diff;
   logic          take;
   logic [RW-1:0] div_ff;
   logic [RW-1:0] rem_ff;
   logic [RW-1:0] rem_in;
   logic [NW-1:0] acc_ff;
   logic [NW-1:0] acc_in;

   // The accumulator shifts dividend bits out at the top and quotient bits in at the bottom.
   assign trial = {in_rem, in_acc[NW-1]};
   assign diff = trial - {1'b0, in_div};
   assign take = trial >= {1'b0, in_div};
   assign rem_in = take ? diff[RW-1:0] : trial[RW-1:0];
   assign acc_in = {in_acc[NW-2:0], take};

   always_ff @(posedge clock) begin
      div_ff <= in_div;
      rem_ff <= rem_in;
      acc_ff <= acc_in;
   end

   assign out_div = div_ff;
   assign out_rem = rem_ff;
   assign out_acc = acc_ff;

endmodule

/* design/ceuler_div_chain.sv */
// A row of NW registered division cells that yields an NW-bit quotient.
`timescale 1ns / 1ps

module ceuler_div_chain #(
   parameter int RW = 31,
   parameter int NW = 32
) (
   input  logic          clock,
   input  logic [RW-1:0] in_div,
   input  logic [RW-1:0] in_rem,
   input  logic [NW-1:0] in_acc,
   output logic [NW-1:0] out_quo
);

   logic [RW-1:0] div_w [NW+1];
   logic [RW-1:0] rem_w [NW+1];
   logic [NW-1:0] acc_w [NW+1];

   assign div_w[0] = in_div;
   assign rem_w[0] = in_rem;
   assign acc_w[0] = in_acc;

   for (genvar i = 0; i < NW; i++) begin : g_cell
      ceuler_div_cell #(
         .RW(RW),
         .NW(NW)
      ) u_cell (
         .clock  (clock),
         .in_div (div_w[i]),
         .in_rem (rem_w[i]),
         .in_acc (acc_w[i]),
         .out_div(div_w[i+1]),
         .out_rem(rem_w[i+1]),
         .out_acc(acc_w[i+1])
      );
   end

   assign out_quo = acc_w[NW];

endmodule

/* design/ceuler_delay.sv */
// Fixed-depth shift line that keeps side data aligned with the division rows.
`timescale 1ns / 1ps

module ceuler_delay #(
   parameter int W = 8,
   parameter int DEPTH = 1
) (
   input  logic         clock,
   input  logic [W-1:0] din,
   output logic [W-1:0] dout
);

   logic [W-1:0] stage_ff [DEPTH];

   always_ff @(posedge clock) begin
      stage_ff[0] <= din;
      for (int i = 1; i < DEPTH; i++) begin
         stage_ff[i] <= stage_ff[i-1];
      end
   end

   assign dout = stage_ff[DEPTH-1];

endmodule

/* design/conserved_to_primitive_euler_core.sv */
// Top level of the conserved-to-primitive Euler core: pipeline stages and division rows.
//
//  Channel   Ports                           Handshake
//  request   start, busy, req_*              taken when start is high and busy is low
//  result    rsp_valid, rsp_*                one-cycle strobe, receiver cannot stall
//  csr       csr_valid, csr_ready, csr_*     written when csr_valid and csr_ready are high
//
// The core takes one request every cycle while reset is low. Its result strobe is the
// accept bit carried down a shift register of valid flags alongside the data.
// The latency is set by the rows of division cells: 63 cells for the kinetic term,
// then 32 cells for the temperature, with the velocity rows running alongside.
// Reset is synchronous; busy is held high and csr_ready low only while reset is high.
// Results cannot be stalled, so nothing inside the pipeline ever waits.
`timescale 1ns / 1ps

module conserved_to_primitive_euler_core #(
   parameter int FRAC_BITS = ceuler_pkg::FRAC_BITS_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   output logic                                busy,
   input  logic signed [ceuler_pkg::WORD_W-1:0] req_density,
   input  logic signed [ceuler_pkg::WORD_W-1:0] req_momentum_x,
   input  logic signed [ceuler_pkg::WORD_W-1:0] req_momentum_y,
   input  logic signed [ceuler_pkg::WORD_W-1:0] req_momentum_z,
   input  logic signed [ceuler_pkg::WORD_W-1:0] req_total_energy,
   input  logic [ceuler_pkg::TAG_W-1:0]         req_node_tag,
   output logic                                rsp_valid,
   output logic signed [ceuler_pkg::WORD_W-1:0] rsp_density_out,
   output logic signed [ceuler_pkg::WORD_W-1:0] rsp_velocity_x,
   output logic signed [ceuler_pkg::WORD_W-1:0] rsp_velocity_y,
   output logic signed [ceuler_pkg::WORD_W-1:0] rsp_velocity_z,
   output logic signed [ceuler_pkg::WORD_W-1:0] rsp_pressure,
   output logic signed [ceuler_pkg::WORD_W-1:0] rsp_temperature,
   output logic [ceuler_pkg::TAG_W-1:0]         rsp_node_tag_out,
   output logic                                rsp_density_fault,
   output logic                                rsp_saturated,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [ceuler_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [ceuler_pkg::WORD_W-1:0]        csr_data
);

   localparam int RW = ceuler_pkg::REG_W;
   localparam int TW = ceuler_pkg::TAG_W;
   localparam int Q_W = 32;
   localparam int KE_W = 63;
   localparam int DEN_W = 2 * RW;
   localparam int VN_W = 32 + FRAC_BITS;
   localparam int VH_W = VN_W - 32;
   localparam int TN_W = 64 + 2 * FRAC_BITS;
   localparam int TH_W = TN_W - 32;
   localparam int CMP_W = (TH_W > DEN_W) ? TH_W : DEN_W;
   localparam int PLO_W = 32 + RW;
   localparam int PHI_W = FRAC_BITS + RW;
   localparam int P_W = FRAC_BITS + 64;
   localparam int T_START = 3 + KE_W + 1;
   localparam int LAT = T_START + Q_W + 2;
   localparam int VEL_HOLD = T_START - 1;
   localparam int KSIDE_W = 32 + DEN_W + 1 + 32 + TW;
   localparam int VSIDE_W = 3 * Q_W + 6;
   localparam int TSIDE_W = 4 + 32 + TW;

   // Configuration registers.
   logic [RW-1:0] gamma_ff;
   logic [RW-1:0] cv_ff;
   logic          accept;
   logic [LAT-1:0] vld_ff;
   logic [LAT-1:0] vld_in;

   assign busy = reset;
   assign csr_ready = ~reset;
   assign accept = start & ~busy;
   assign vld_in = {vld_ff[LAT-2:0], accept};

   always_ff @(posedge clock) begin
      if (reset) begin
         gamma_ff <= ceuler_pkg::GAMMA_RESET;
         cv_ff <= ceuler_pkg::CV_RESET;
         vld_ff <= '0;
      end else begin
         vld_ff <= vld_in;
         if (csr_valid && csr_ready) begin
            case (csr_index)
               ceuler_pkg::CSR_GAMMA: gamma_ff <= csr_data[RW-1:0];
               ceuler_pkg::CSR_CV:    cv_ff <= csr_data[RW-1:0];
               default: ;
            endcase
         end
      end
   end

   // Stage 0: captured request.
   logic signed [31:0] s0_rho_ff;
   logic signed [31:0] s0_mom_ff [3];
   logic signed [31:0] s0_energy_ff;
   logic [TW-1:0]      s0_tag_ff;

   always_ff @(posedge clock) begin
      s0_rho_ff <= req_density;
      s0_mom_ff[0] <= req_momentum_x;
      s0_mom_ff[1] <= req_momentum_y;
      s0_mom_ff[2] <= req_momentum_z;
      s0_energy_ff <= req_total_energy;
      s0_tag_ff <= req_node_tag;
   end

   // Stage 1: magnitudes, squares, velocity division set-up and rho*cv.
   logic [RW-1:0]      s1_vrem_in [3];
   logic [Q_W-1:0]     s1_vacc_in [3];
   logic [2:0]         s1_vovf_in;
   logic [2:0]         s1_vneg_in;
   logic [63:0]        s1_sq_in [3];
   logic [RW-1:0]      s1_vrem_ff [3];
   logic [Q_W-1:0]     s1_vacc_ff [3];
   logic [2:0]         s1_vovf_ff;
   logic [2:0]         s1_vneg_ff;
   logic [63:0]        s1_sq_ff [3];
   logic [DEN_W-1:0]   s1_den_ff;
   logic               s1_fault_ff;
   logic signed [31:0] s1_rho_ff;
   logic signed [31:0] s1_energy_ff;
   logic [TW-1:0]      s1_tag_ff;

   always_comb begin
      logic [31:0]     mag;
      logic [VN_W-1:0] vn;
      logic [VH_W-1:0] vh;
      for (int k = 0; k < 3; k++) begin
         s1_vneg_in[k] = s0_mom_ff[k][31];
         mag = s0_mom_ff[k][31] ? 32'd0 - s0_mom_ff[k] : s0_mom_ff[k];
         vn = VN_W'(mag) << FRAC_BITS;
         vh = vn[VN_W-1:32];
         s1_vrem_in[k] = RW'(vh);
         s1_vovf_in[k] = RW'(vh) >= s0_rho_ff[RW-1:0];
         s1_vacc_in[k] = vn[31:0];
         s1_sq_in[k] = 64'(mag) * 64'(mag);
      end
   end

   always_ff @(posedge clock) begin
      for (int k = 0; k < 3; k++) begin
         s1_vrem_ff[k] <= s1_vrem_in[k];
         s1_vacc_ff[k] <= s1_vacc_in[k];
         s1_sq_ff[k] <= s1_sq_in[k];
      end
      s1_vovf_ff <= s1_vovf_in;
      s1_vneg_ff <= s1_vneg_in;
      s1_den_ff <= DEN_W'(s0_rho_ff[RW-1:0]) * DEN_W'(cv_ff);
      s1_fault_ff <= s0_rho_ff <= 32'sd0;
      s1_rho_ff <= s0_rho_ff;
      s1_energy_ff <= s0_energy_ff;
      s1_tag_ff <= s0_tag_ff;
   end

   // Velocity rows.
   logic [Q_W-1:0] vquo [3];

   for (genvar k = 0; k < 3; k++) begin : g_vel
      ceuler_div_chain #(
         .RW(RW),
         .NW(Q_W)
      ) u_vel_div (
         .clock  (clock),
         .in_div (s1_rho_ff[RW-1:0]),
         .in_rem (s1_vrem_ff[k]),
         .in_acc (s1_vacc_ff[k]),
         .out_quo(vquo[k])
      );
   end

   logic [5:0] vflag_d;

   ceuler_delay #(
      .W    (6),
      .DEPTH(Q_W)
   ) u_vflag_dly (
      .clock(clock),
      .din  ({s1_vovf_ff, s1_vneg_ff}),
      .dout (vflag_d)
   );

   logic [VSIDE_W-1:0] vside_d;

   ceuler_delay #(
      .W    (VSIDE_W),
      .DEPTH(VEL_HOLD)
   ) u_vres_dly (
      .clock(clock),
      .din  ({vquo[0], vquo[1], vquo[2], vflag_d}),
      .dout (vside_d)
   );

   // Stage 2: sum of squared momenta.
   logic [63:0]        s2_sum_ff;
   logic [DEN_W-1:0]   s2_den_ff;
   logic               s2_fault_ff;
   logic signed [31:0] s2_rho_ff;
   logic signed [31:0] s2_energy_ff;
   logic [TW-1:0]      s2_tag_ff;

   always_ff @(posedge clock) begin
      s2_sum_ff <= s1_sq_ff[0] + s1_sq_ff[1] + s1_sq_ff[2];
      s2_den_ff <= s1_den_ff;
      s2_fault_ff <= s1_fault_ff;
      s2_rho_ff <= s1_rho_ff;
      s2_energy_ff <= s1_energy_ff;
      s2_tag_ff <= s1_tag_ff;
   end

   // Kinetic term: floor(sum/2) divided by density.
   logic [KE_W-1:0]    ke_quo;
   logic [KSIDE_W-1:0] kside_d;

   ceuler_div_chain #(
      .RW(RW),
      .NW(KE_W)
   ) u_ke_div (
      .clock  (clock),
      .in_div (s2_rho_ff[RW-1:0]),
      .in_rem ('0),
      .in_acc (s2_sum_ff[63:1]),
      .out_quo(ke_quo)
   );

   ceuler_delay #(
      .W    (KSIDE_W),
      .DEPTH(KE_W)
   ) u_kside_dly (
      .clock(clock),
      .din  ({s2_energy_ff, s2_den_ff, s2_fault_ff, s2_rho_ff, s2_tag_ff}),
      .dout (kside_d)
   );

   logic signed [31:0] k_energy;
   logic [DEN_W-1:0]   k_den;
   logic               k_fault;
   logic signed [31:0] k_rho;
   logic [TW-1:0]      k_tag;

   assign {k_energy, k_den, k_fault, k_rho, k_tag} = kside_d;

   // Internal energy.
   logic [64:0]        e_eint_in;
   logic [63:0]        e_emag_ff;
   logic               e_eneg_ff;
   logic [DEN_W-1:0]   e_den_ff;
   logic               e_fault_ff;
   logic signed [31:0] e_rho_ff;
   logic [TW-1:0]      e_tag_ff;

   assign e_eint_in = {{33{k_energy[31]}}, k_energy} - {2'b00, ke_quo};

   always_ff @(posedge clock) begin
      e_eneg_ff <= e_eint_in[64];
      e_emag_ff <= e_eint_in[64] ? 64'(65'd0 - e_eint_in) : e_eint_in[63:0];
      e_den_ff <= k_den;
      e_fault_ff <= k_fault;
      e_rho_ff <= k_rho;
      e_tag_ff <= k_tag;
   end

   // Temperature division set-up and pressure partial products.
   logic [TN_W-1:0]    t_num_in;
   logic [TH_W-1:0]    t_head_in;
   logic [DEN_W-1:0]   t_den_ff;
   logic [DEN_W-1:0]   t_rem_ff;
   logic [Q_W-1:0]     t_acc_ff;
   logic               t_ovf_ff;
   logic               t_zero_ff;
   logic               t_pbig_ff;
   logic               t_pgz_ff;
   logic [PLO_W-1:0]   t_plo_ff;
   logic [PHI_W-1:0]   t_phi_ff;
   logic               t_eneg_ff;
   logic               t_fault_ff;
   logic signed [31:0] t_rho_ff;
   logic [TW-1:0]      t_tag_ff;

   assign t_num_in = TN_W'(e_emag_ff) << (2 * FRAC_BITS);
   assign t_head_in = t_num_in[TN_W-1:32];

   always_ff @(posedge clock) begin
      t_den_ff <= e_den_ff;
      t_rem_ff <= DEN_W'(t_head_in);
      t_acc_ff <= t_num_in[31:0];
      t_ovf_ff <= CMP_W'(t_head_in) >= CMP_W'(e_den_ff);
      t_zero_ff <= e_den_ff == '0;
      t_pbig_ff <= e_emag_ff[63:FRAC_BITS+32] != '0;
      t_pgz_ff <= gamma_ff == '0;
      t_plo_ff <= PLO_W'(e_emag_ff[31:0]) * PLO_W'(gamma_ff);
      t_phi_ff <= PHI_W'(e_emag_ff[FRAC_BITS+31:32]) * PHI_W'(gamma_ff);
      t_eneg_ff <= e_eneg_ff;
      t_fault_ff <= e_fault_ff;
      t_rho_ff <= e_rho_ff;
      t_tag_ff <= e_tag_ff;
   end

   logic [Q_W-1:0] t_quo;

   ceuler_div_chain #(
      .RW(DEN_W),
      .NW(Q_W)
   ) u_temp_div (
      .clock  (clock),
      .in_div (t_den_ff),
      .in_rem (t_rem_ff),
      .in_acc (t_acc_ff),
      .out_quo(t_quo)
   );

   logic [TSIDE_W-1:0] tside_d;

   ceuler_delay #(
      .W    (TSIDE_W),
      .DEPTH(Q_W)
   ) u_tside_dly (
      .clock(clock),
      .din  ({t_eneg_ff, t_ovf_ff, t_zero_ff, t_fault_ff, t_rho_ff, t_tag_ff}),
      .dout (tside_d)
   );

   // Pressure magnitude.
   logic [P_W-1:0] p_prod_in;
   logic [63:0]    p_res_in;
   logic [32:0]    p_mag_in;
   logic [32:0]    p_mag_ff;
   logic [32:0]    p_mag_d;

   always_comb begin
      p_prod_in = (P_W'(t_phi_ff) << 32) + P_W'(t_plo_ff);
      p_res_in = p_prod_in[P_W-1:FRAC_BITS];
      if (t_pgz_ff) begin
         p_mag_in = '0;
      end else if (t_pbig_ff || p_res_in >= 64'(ceuler_pkg::MAG_LIMIT)) begin
         p_mag_in = ceuler_pkg::MAG_LIMIT;
      end else begin
         p_mag_in = p_res_in[32:0];
      end
   end

   always_ff @(posedge clock) begin
      p_mag_ff <= p_mag_in;
   end

   ceuler_delay #(
      .W    (33),
      .DEPTH(Q_W - 1)
   ) u_pres_dly (
      .clock(clock),
      .din  (p_mag_ff),
      .dout (p_mag_d)
   );

   // Output stage: signs, saturation and the density fault.
   logic [Q_W-1:0]     o_vquo [3];
   logic [2:0]         o_vovf;
   logic [2:0]         o_vneg;
   logic               o_eneg;
   logic               o_tovf;
   logic               o_tzero;
   logic               o_fault;
   logic signed [31:0] o_rho;
   logic [TW-1:0]      o_tag;

   assign {o_vquo[0], o_vquo[1], o_vquo[2], o_vovf, o_vneg} = vside_d;
   assign {o_eneg, o_tovf, o_tzero, o_fault, o_rho, o_tag} = tside_d;

   logic [31:0] o_vel_in [3];
   logic [31:0] o_pres_in;
   logic [31:0] o_temp_in;
   logic        o_sat_in;
   logic [31:0] o_vel_ff [3];
   logic [31:0] o_pres_ff;
   logic [31:0] o_temp_ff;
   logic        o_sat_ff;
   logic        o_fault_ff;
   logic [31:0] o_rho_ff;
   logic [TW-1:0] o_tag_ff;

   always_comb begin
      ceuler_pkg::sat_word_type r;
      logic [32:0]              mag;
      o_sat_in = 1'b0;
      for (int k = 0; k < 3; k++) begin
         mag = o_vovf[k] ? ceuler_pkg::MAG_LIMIT : {1'b0, o_vquo[k]};
         r = ceuler_pkg::sat_to_s32(o_vneg[k], mag);
         o_vel_in[k] = r[31:0];
         o_sat_in = o_sat_in | r[32];
      end
      r = ceuler_pkg::sat_to_s32(o_eneg, p_mag_d);
      o_pres_in = r[31:0];
      o_sat_in = o_sat_in | r[32];
      if (o_tzero) begin
         o_temp_in = '0;
      end else begin
         mag = o_tovf ? ceuler_pkg::MAG_LIMIT : {1'b0, t_quo};
         r = ceuler_pkg::sat_to_s32(o_eneg, mag);
         o_temp_in = r[31:0];
         o_sat_in = o_sat_in | r[32];
      end
      if (o_fault) begin
         for (int k = 0; k < 3; k++) begin
            o_vel_in[k] = '0;
         end
         o_pres_in = '0;
         o_temp_in = '0;
         o_sat_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      for (int k = 0; k < 3; k++) begin
         o_vel_ff[k] <= o_vel_in[k];
      end
      o_pres_ff <= o_pres_in;
      o_temp_ff <= o_temp_in;
      o_sat_ff <= o_sat_in;
      o_fault_ff <= o_fault;
      o_rho_ff <= o_rho;
      o_tag_ff <= o_tag;
   end

   assign rsp_valid = vld_ff[LAT-1];
   assign rsp_density_out = o_rho_ff;
   assign rsp_velocity_x = o_vel_ff[0];
   assign rsp_velocity_y = o_vel_ff[1];
   assign rsp_velocity_z = o_vel_ff[2];
   assign rsp_pressure = o_pres_ff;
   assign rsp_temperature = o_temp_ff;
   assign rsp_node_tag_out = o_tag_ff;
   assign rsp_density_fault = o_fault_ff;
   assign rsp_saturated = o_sat_ff;

endmodule
